### rtl/cal_pkg.sv
package cal_pkg;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_ATTACH  = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] entry_value;
  } cal_in_t;

  typedef struct packed {
    logic [31:0] current_word;
    logic        has_current;
    logic [5:0]  item_count;
    logic        rejected;
  } cal_out_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic shift_up;    // take the left neighbor's word above pos
    logic shift_down;  // take the right neighbor's word at and above pos
    logic write;       // store the new word at pos
  } cal_cell_ctl_t;

endpackage

### rtl/cal_cell.sv
module cal_cell
  import cal_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 6,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  cal_cell_ctl_t        ctl_i,
  input  logic [IDX_W-1:0]     pos_i,
  input  logic [WORD_BITS-1:0] wr_word_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] rd_word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.write && (MyIdx == pos_i)) begin
      word_d = wr_word_i;
    end else if (ctl_i.shift_up && (MyIdx > pos_i)) begin
      word_d = left_i;
    end else if (ctl_i.shift_down && (MyIdx >= pos_i)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (MyIdx == rd_idx_i) ? word_q : '0;

endmodule

### rtl/cursor_array_list.sv
// Ordered list of up to CAPACITY_WORDS words with a cursor, held in a row of
// cells, one word per cell. Every operation shifts, writes or reads all cells
// at once, so the block takes one item per clock cycle unless its output stalls
// and answers each with one result, in an output register, in the next cycle;
// a new item is accepted whenever that register is empty or is being taken
// in the same cycle. Opcodes six and seven act as a query and are not rejected.
module cursor_array_list
  import cal_pkg::*;
#(
  parameter int CAPACITY_WORDS = 32,
  parameter int WORD_BITS      = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cal_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cal_out_t out_data_o
);

  localparam int CntW = $clog2(CAPACITY_WORDS + 1);
  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY_WORDS);

  logic [CntW-1:0] cnt_q, cnt_d, cur_q, cur_d;
  logic            out_valid_q;
  cal_out_t        out_q;

  logic            accept;
  logic            cur_ok, full, rej, use_new;
  cal_cell_ctl_t   ctl;
  logic [CntW-1:0] pos, rd_idx;
  logic [63:0]     in_ext, rd_ext;
  logic [WORD_BITS-1:0] new_word, rd_word, cur_word;
  logic [WORD_BITS-1:0] words    [CAPACITY_WORDS];
  logic [WORD_BITS-1:0] rd_words [CAPACITY_WORDS];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign in_ext   = 64'(in_data_i.entry_value);
  assign new_word = in_ext[WORD_BITS-1:0];

  assign cur_ok = cur_q < cnt_q;
  assign full   = cnt_q == Cap;

  always_comb begin
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    rej     = 1'b0;
    ctl     = '0;
    pos     = cur_q;
    rd_idx  = cur_q;
    use_new = 1'b0;
    case (op_e'(in_data_i.opcode))
      OP_START: begin
        cur_d  = '0;
        rd_idx = '0;
      end
      OP_ADVANCE: begin
        if (cur_ok) begin
          cur_d  = cur_q + CntW'(1);
          rd_idx = cur_q + CntW'(1);
        end else begin
          rej = 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          rej = 1'b1;
        end else begin
          pos          = cur_ok ? cur_q : '0;
          ctl.shift_up = 1'b1;
          ctl.write    = 1'b1;
          cur_d        = pos;
          cnt_d        = cnt_q + CntW'(1);
          use_new      = 1'b1;
        end
      end
      OP_ATTACH: begin
        if (full) begin
          rej = 1'b1;
        end else begin
          // with no current element, write past the end; the shift is harmless
          pos          = cur_ok ? cur_q + CntW'(1) : cnt_q;
          ctl.shift_up = 1'b1;
          ctl.write    = 1'b1;
          cur_d        = pos;
          cnt_d        = cnt_q + CntW'(1);
          use_new      = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cur_ok) begin
          ctl.shift_down = 1'b1;
          cnt_d          = cnt_q - CntW'(1);
          rd_idx         = cur_q + CntW'(1);
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl   = '0;
      cnt_d = cnt_q;
      cur_d = cur_q;
    end
  end

  for (genvar i = 0; i < CAPACITY_WORDS; i++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == CAPACITY_WORDS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    cal_cell #(
      .WORD_BITS(WORD_BITS),
      .IDX_W    (CntW),
      .IDX      (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .pos_i    (pos),
      .wr_word_i(new_word),
      .left_i   (left),
      .right_i  (right),
      .rd_idx_i (rd_idx),
      .word_o   (words[i]),
      .rd_word_o(rd_words[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY_WORDS; i++) begin
      rd_word = rd_word | rd_words[i];
    end
  end

  assign cur_word = use_new ? new_word : rd_word;
  assign rd_ext   = 64'(cur_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.has_current  <= cur_d < cnt_d;
      out_q.current_word <= (cur_d < cnt_d) ? rd_ext[31:0] : '0;
      out_q.item_count   <= 6'(cnt_d);
      out_q.rejected     <= rej;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
